FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the Hall speed estimator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: property does not hold");

// Antecedent at one edge requires the consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication violated");

`endif

FILE: sv/hsde_pkg.sv
// ----------------------------------------------------------------------------
// hsde_pkg
// Types, constants and the sector table of the Hall speed estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package hsde_pkg;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;
   localparam int DIV_STEPS   = 32;

   // Direction codes as reported on the result channel.
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_POS  = 2'd1;
   localparam logic [1:0] DIR_NEG  = 2'd2;

   // Sector differences that mark a step in either direction.
   localparam logic signed [3:0] DIFF_POS_STEP = -4'sd1;
   localparam logic signed [3:0] DIFF_POS_WRAP = 4'sd5;
   localparam logic signed [3:0] DIFF_NEG_STEP = 4'sd1;
   localparam logic signed [3:0] DIFF_NEG_WRAP = -4'sd5;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SPEED_SCALE      = 2'd0;
   localparam logic [1:0] CSR_PER_UNIT_FACTOR  = 2'd1;
   localparam logic [1:0] CSR_STALL_TICK_LIMIT = 2'd2;

   typedef struct packed {
      logic capture;     // latch the incoming request
      logic stall_step;  // tick without a code change
      logic edge_start;  // code changed: average interval, arm divider
      logic div_step;    // one restoring divide iteration
      logic mul;         // quotient times per-unit factor
      logic commit;      // apply direction and update state
      logic load_out;    // load the result register
   } hsde_cmd_type;

   typedef struct packed {
      logic code_change;
   } hsde_status_type;

   // Sector number of each inverted Hall code.
   function automatic logic signed [3:0] sector_of(input logic [2:0] code);
      logic signed [3:0] s;
      unique case (code)
         3'd0:    s = 4'sd4;
         3'd1:    s = 4'sd1;
         3'd2:    s = 4'sd5;
         3'd3:    s = 4'sd6;
         3'd4:    s = 4'sd3;
         3'd5:    s = 4'sd2;
         3'd6:    s = 4'sd4;
         default: s = 4'sd1;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

FILE: sv/hsde_ctrl.sv
// ----------------------------------------------------------------------------
// hsde_ctrl
// Sequencer: walks each request through evaluate (divide, multiply, commit
// only on a code change) and result load, and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module hsde_ctrl
   import hsde_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   input  wire hsde_status_type status,
   output hsde_cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EVAL = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;
   logic             out_free;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.code_change) begin
               cmd.edge_start = 1'b1;
               cnt_in         = '0;
               state_in       = ST_DIV;
            end else begin
               cmd.stall_step = 1'b1;
               state_in       = ST_DONE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.commit = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/hsde_datapath.sv
// ----------------------------------------------------------------------------
// hsde_datapath
// Estimator state, configuration registers, interval averaging, restoring
// divider, multiplier, direction logic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsde_datapath
   import hsde_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [1:0]             csr_index,
   input  wire logic [31:0]            csr_wdata,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire hsde_cmd_type           cmd,
   output hsde_status_type             status
);

   // Configuration.
   logic [31:0] scale_ff;
   logic [31:0] factor_ff;
   logic [15:0] limit_ff;

   // Estimator state.
   logic [2:0]  last_code_ff;
   logic [31:0] last_time_ff;
   logic [31:0] avg_ff;
   logic [1:0]  last_dir_ff;
   logic [15:0] stall_ff;
   logic [31:0] speed_ff;

   // Per-request working registers.
   logic [2:0]  code_ff;
   logic [31:0] now_ff;
   logic [1:0]  new_dir_ff;
   logic        edge_ff;
   logic [31:0] rem_ff;
   logic [31:0] quo_ff;
   logic [31:0] prod_ff;
   logic [RSP_TDATA_W-1:0] out_ff;

   logic [31:0]       elapsed;
   logic [32:0]       avg_sum;
   logic signed [3:0] diff;
   logic [1:0]        dir_calc;
   logic [32:0]       trial_src;
   logic [32:0]       trial;
   logic [31:0]       prod_full;
   logic [15:0]       stall_inc;
   logic [31:0]       spd_signed;

   assign status.code_change = (code_ff != last_code_ff);

   assign elapsed = last_time_ff - now_ff;
   assign avg_sum = {1'b0, elapsed} + {1'b0, avg_ff};

   assign diff = sector_of(code_ff) - sector_of(last_code_ff);

   always_comb begin
      if (diff == DIFF_POS_STEP || diff == DIFF_POS_WRAP) begin
         dir_calc = DIR_POS;
      end else if (diff == DIFF_NEG_STEP || diff == DIFF_NEG_WRAP) begin
         dir_calc = DIR_NEG;
      end else begin
         dir_calc = DIR_NONE;
      end
   end

   // One restoring step; a zero divisor yields all ones, as required.
   assign trial_src = {rem_ff, quo_ff[31]};
   assign trial     = trial_src - {1'b0, avg_ff};

   // Only the low 32 bits of the product are kept.
   assign prod_full = quo_ff * factor_ff;
   assign stall_inc = stall_ff + 16'd1;

   always_comb begin
      spd_signed = prod_ff;
      if (new_dir_ff == DIR_NEG) begin
         spd_signed = 32'd0 - prod_ff;
      end
      if (new_dir_ff != last_dir_ff) begin
         spd_signed = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= '0;
         factor_ff <= '0;
         limit_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SPEED_SCALE:      scale_ff  <= csr_wdata;
            CSR_PER_UNIT_FACTOR:  factor_ff <= csr_wdata;
            CSR_STALL_TICK_LIMIT: limit_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_code_ff <= '0;
         last_time_ff <= '0;
         avg_ff       <= '0;
         last_dir_ff  <= DIR_NONE;
         stall_ff     <= '0;
         speed_ff     <= '0;
      end else begin
         if (cmd.stall_step) begin
            if (stall_inc > limit_ff) begin
               stall_ff <= '0;
               speed_ff <= '0;
            end else begin
               stall_ff <= stall_inc;
            end
         end
         if (cmd.edge_start) begin
            last_time_ff <= now_ff;
            avg_ff       <= avg_sum[32:1];
            stall_ff     <= '0;
         end
         if (cmd.commit) begin
            speed_ff     <= spd_signed;
            last_code_ff <= code_ff;
            last_dir_ff  <= new_dir_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         code_ff <= ~req_tdata[2:0];
         now_ff  <= req_tdata[34:3];
      end
      if (cmd.stall_step) begin
         edge_ff <= 1'b0;
      end
      if (cmd.edge_start) begin
         edge_ff    <= 1'b1;
         new_dir_ff <= dir_calc;
         rem_ff     <= '0;
         quo_ff     <= scale_ff;
      end
      if (cmd.div_step) begin
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= trial_src[31:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
      if (cmd.mul) begin
         prod_ff <= prod_full;
      end
      if (cmd.load_out) begin
         out_ff <= {2'b00, edge_ff, last_code_ff, last_dir_ff, speed_ff};
      end
   end

   assign rsp_tdata = out_ff;

endmodule

`default_nettype wire

FILE: sv/hall_speed_direction_estimator_top.sv
// ----------------------------------------------------------------------------
// hall_speed_direction_estimator_top
// Hall sensor speed and direction estimator, one request per PWM tick.
// ----------------------------------------------------------------------------
// Each request carries the active-low Hall levels and a down-counting timer
// value and produces exactly one result holding the speed, direction and
// stored Hall code after that tick. A tick without a Hall code change passes
// through capture, evaluate and result load. A tick with a code change
// averages the new edge interval with the running average, divides the
// speed scale by that average in a restoring divider that retires one
// quotient bit per cycle over 32 iterations, multiplies by the per-unit
// factor and applies the sector direction. The block handles one request at
// a time; a new request is accepted as soon as the previous result has been
// loaded into the output register, even while that result still waits for
// rsp_tready. Configuration registers should be written only while no
// request is in flight.
`default_nettype none

module hall_speed_direction_estimator_top
   import hsde_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Configuration write port.
   input  wire logic                   csr_write_enable,
   input  wire logic [1:0]             csr_index,
   input  wire logic [31:0]            csr_wdata,
   // Request stream.
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [2:0] hall_levels, [34:3] timer_count, [39:35] zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // Result stream.
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [31:0] speed_feedback, [33:32] direction, [36:34] hall_state,
   // [37] edge_seen, [39:38] zero
   output logic      [RSP_TDATA_W-1:0] rsp_tdata
);

   hsde_cmd_type    cmd;
   hsde_status_type status;

   hsde_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_tdata        (req_tdata),
      .rsp_tdata        (rsp_tdata),
      .cmd              (cmd),
      .status           (status)
   );

   hsde_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

`include "assert_macros.svh"

   // The sequencer issues at most one datapath command per cycle.
   `ASSERT_HOLDS(a_cmd_onehot, clock, reset, $onehot0(cmd))
   // An accepted request keeps the input closed on the following cycle.
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   // The reported direction is never the unused code.
   `ASSERT_HOLDS(a_dir_legal, clock, reset, !rsp_tvalid || rsp_tdata[33:32] != 2'b11)

endmodule

`default_nettype wire
